// File: hdl/jst_pkg.sv
// Shared definitions for the job slot table: opcodes, status codes,
// the default table size and the control structs between the modules.
// No dependencies.
package jst_pkg;

   localparam int SLOT_COUNT_DEFAULT = 16;

   localparam logic [1:0] OP_INSTALL = 2'd0;
   localparam logic [1:0] OP_SELECT  = 2'd1;
   localparam logic [1:0] OP_CLOSE   = 2'd2;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_CLOSED  = 2'd1,
      STATUS_WAIT    = 2'd2,
      STATUS_INVALID = 2'd3
   } status_type;

   // Commands from the sequencer to the scan unit.
   typedef struct packed {
      logic start;        // begin a scan
      logic select_mode;  // 1: look for a new slot, 0: look for an empty slot
      logic close;        // free the slot on the close index
   } scan_ctrl_type;

   // Answers from the scan unit to the sequencer.
   typedef struct packed {
      logic hit;          // current slot matches; it is taken
      logic miss;         // a whole round passed without a match
      logic close_occ;    // slot on the close index holds a job
      logic close_own;    // slot on the close index has an owner
   } scan_stat_type;

endpackage

// File: hdl/jst_ram.sv
// Generic memory with one write port and one registered read port.
// No dependencies.
module jst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/jst_scan.sv
// Round-robin slot scanner: per-slot occupied and owned flags, the install
// and select pointers, and the one-slot-per-cycle match check.
// Depends on jst_pkg.
module jst_scan #(
   parameter int SLOT_COUNT = jst_pkg::SLOT_COUNT_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  jst_pkg::scan_ctrl_type        ctrl,
   input  logic [$clog2(SLOT_COUNT)-1:0] close_idx,
   output jst_pkg::scan_stat_type        stat,
   output logic [$clog2(SLOT_COUNT)-1:0] scan_slot
);

   localparam int IDX_W = $clog2(SLOT_COUNT);
   localparam logic [IDX_W-1:0] LAST = IDX_W'(SLOT_COUNT - 1);

   logic [SLOT_COUNT-1:0] occ_ff, occ_in;
   logic [SLOT_COUNT-1:0] own_ff, own_in;
   logic [IDX_W-1:0]      ins_ptr_ff, ins_ptr_in;
   logic [IDX_W-1:0]      sel_ptr_ff, sel_ptr_in;
   logic [IDX_W-1:0]      step_ff, step_in;
   logic                  active_ff, active_in;
   logic                  mode_ff, mode_in;

   logic [IDX_W-1:0] cur;
   logic [IDX_W-1:0] cur_next;
   logic             match;

   assign cur      = mode_ff ? sel_ptr_ff : ins_ptr_ff;
   assign cur_next = (cur == LAST) ? '0 : cur + 1'b1;
   // A new slot holds a job without an owner; an empty slot holds neither.
   assign match    = mode_ff ? (occ_ff[cur] & ~own_ff[cur])
                             : (~occ_ff[cur] & ~own_ff[cur]);

   always_comb begin
      occ_in     = occ_ff;
      own_in     = own_ff;
      ins_ptr_in = ins_ptr_ff;
      sel_ptr_in = sel_ptr_ff;
      step_in    = step_ff;
      active_in  = active_ff;
      mode_in    = mode_ff;
      stat       = '0;

      stat.close_occ = occ_ff[close_idx];
      stat.close_own = own_ff[close_idx];

      if (ctrl.start) begin
         active_in = 1'b1;
         mode_in   = ctrl.select_mode;
         step_in   = '0;
      end else if (active_ff) begin
         if (mode_ff) begin
            sel_ptr_in = cur_next;
         end else begin
            ins_ptr_in = cur_next;
         end
         if (match) begin
            stat.hit  = 1'b1;
            active_in = 1'b0;
            if (mode_ff) begin
               own_in[cur] = 1'b1;
            end else begin
               occ_in[cur] = 1'b1;
            end
         end else if (step_ff == LAST) begin
            stat.miss = 1'b1;
            active_in = 1'b0;
         end else begin
            step_in = step_ff + 1'b1;
         end
      end

      if (ctrl.close) begin
         occ_in[close_idx] = 1'b0;
         own_in[close_idx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff     <= '0;
         own_ff     <= '0;
         ins_ptr_ff <= '0;
         sel_ptr_ff <= '0;
         step_ff    <= '0;
         active_ff  <= 1'b0;
         mode_ff    <= 1'b0;
      end else begin
         occ_ff     <= occ_in;
         own_ff     <= own_in;
         ins_ptr_ff <= ins_ptr_in;
         sel_ptr_ff <= sel_ptr_in;
         step_ff    <= step_in;
         active_ff  <= active_in;
         mode_ff    <= mode_in;
      end
   end

   assign scan_slot = cur;

endmodule

// File: hdl/job_slot_table_round_robin_unit.sv
// Job slot table with round-robin install, select and close.
// Depends on jst_pkg, jst_scan and jst_ram.
//
// Usage: raise start with a request on the req_ ports while busy is low;
// the request is taken at that clock edge and busy stays high until the
// result has been formed. The result appears on the rsp_ ports for exactly
// one cycle, marked by rsp_valid, and the receiver cannot stall it, so it
// must be captured in that cycle. A close, a refused or an invalid request
// is answered from the decode state; an install passes on to the scan
// state, where the scan unit inspects one slot per cycle, and a select
// also passes through a fetch state, since its class, name and id come
// from a memory with a registered read. The scan unit is shared by
// install and select.
// The accepting register is written through csr_wr_en and csr_wr_data and
// should only be changed while no request is in flight.
module job_slot_table_round_robin_unit #(
   parameter int SLOT_COUNT = jst_pkg::SLOT_COUNT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_opcode,
   input  logic [31:0] req_job_class,
   input  logic [31:0] req_job_name,
   input  logic [31:0] req_owner_id,
   input  logic [3:0]  req_close_slot,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [3:0]  rsp_slot,
   output logic [31:0] rsp_job_id,
   output logic [31:0] rsp_class_out,
   output logic [31:0] rsp_name_out,
   output logic        rsp_all_empty,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);

   localparam int IDX_W = $clog2(SLOT_COUNT);
   localparam int CNT_W = $clog2(SLOT_COUNT + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(SLOT_COUNT);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_FETCH
   } state_type;

   state_type   state_ff, state_in;

   // Request held for the length of its processing.
   logic [1:0]  req_opcode_ff, req_opcode_in;
   logic [31:0] req_class_ff, req_class_in;
   logic [31:0] req_name_ff, req_name_in;
   logic [31:0] req_owner_ff, req_owner_in;
   logic [3:0]  req_close_ff, req_close_in;

   // Table bookkeeping.
   logic             accepting_ff, accepting_in;
   logic [CNT_W-1:0] new_count_ff, new_count_in;
   logic [CNT_W-1:0] empty_count_ff, empty_count_in;
   logic [31:0]      next_id_ff, next_id_in;

   // Registered result.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic [3:0]  rsp_slot_ff, rsp_slot_in;
   logic [31:0] rsp_job_id_ff, rsp_job_id_in;
   logic [31:0] rsp_class_ff, rsp_class_in;
   logic [31:0] rsp_name_ff, rsp_name_in;
   logic        rsp_all_empty_ff, rsp_all_empty_in;

   jst_pkg::scan_ctrl_type scan_ctrl;
   jst_pkg::scan_stat_type scan_stat;
   logic [IDX_W-1:0]       scan_slot;
   logic [IDX_W-1:0]       close_idx;
   logic                   close_in_range;

   logic        ram_wr_en;
   logic        ram_rd_en;
   logic [31:0] class_rd;
   logic [31:0] name_rd;
   logic [31:0] id_rd;

   assign close_idx      = IDX_W'(req_close_ff);
   assign close_in_range = 32'(req_close_ff) < 32'(SLOT_COUNT);

   jst_scan #(
      .SLOT_COUNT(SLOT_COUNT)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (scan_ctrl),
      .close_idx (close_idx),
      .stat      (scan_stat),
      .scan_slot (scan_slot)
   );

   // Class, name and id of each slot. The class memory is read only for
   // slots whose occupied flag is set, so it needs no clearing.
   jst_ram #(.WIDTH(32), .DEPTH(SLOT_COUNT)) u_class_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (scan_slot),
      .wr_data (req_class_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (scan_slot),
      .rd_data (class_rd)
   );

   jst_ram #(.WIDTH(32), .DEPTH(SLOT_COUNT)) u_name_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (scan_slot),
      .wr_data (req_name_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (scan_slot),
      .rd_data (name_rd)
   );

   jst_ram #(.WIDTH(32), .DEPTH(SLOT_COUNT)) u_id_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (scan_slot),
      .wr_data (next_id_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (scan_slot),
      .rd_data (id_rd)
   );

   always_comb begin
      state_in       = state_ff;
      req_opcode_in  = req_opcode_ff;
      req_class_in   = req_class_ff;
      req_name_in    = req_name_ff;
      req_owner_in   = req_owner_ff;
      req_close_in   = req_close_ff;
      accepting_in   = csr_wr_en ? csr_wr_data : accepting_ff;
      new_count_in   = new_count_ff;
      empty_count_in = empty_count_ff;
      next_id_in     = next_id_ff;
      rsp_valid_in   = 1'b0;
      rsp_status_in  = rsp_status_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_job_id_in  = rsp_job_id_ff;
      rsp_class_in   = rsp_class_ff;
      rsp_name_in    = rsp_name_ff;
      scan_ctrl      = '0;
      ram_wr_en      = 1'b0;
      ram_rd_en      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_opcode_in = req_opcode;
               req_class_in  = req_job_class;
               req_name_in   = req_job_name;
               req_owner_in  = req_owner_id;
               req_close_in  = req_close_slot;
               state_in      = ST_DECODE;
            end
         end

         ST_DECODE: begin
            // Fields without meaning for a result are reported as zero.
            rsp_slot_in   = '0;
            rsp_job_id_in = '0;
            rsp_class_in  = '0;
            rsp_name_in   = '0;
            rsp_status_in = jst_pkg::STATUS_INVALID;
            state_in      = ST_IDLE;
            rsp_valid_in  = 1'b1;

            if (req_opcode_ff == jst_pkg::OP_INSTALL) begin
               priority if (req_class_ff == '0) begin
                  rsp_status_in = jst_pkg::STATUS_INVALID;
               end else if (!accepting_ff) begin
                  rsp_status_in = jst_pkg::STATUS_CLOSED;
               end else if (empty_count_ff == '0) begin
                  rsp_status_in = jst_pkg::STATUS_WAIT;
               end else begin
                  scan_ctrl.start       = 1'b1;
                  scan_ctrl.select_mode = 1'b0;
                  rsp_valid_in          = 1'b0;
                  state_in              = ST_SCAN;
               end
            end else if (req_opcode_ff == jst_pkg::OP_SELECT) begin
               priority if (req_owner_ff == '0) begin
                  rsp_status_in = jst_pkg::STATUS_INVALID;
               end else if (new_count_ff == '0) begin
                  rsp_status_in = accepting_ff ? jst_pkg::STATUS_WAIT
                                               : jst_pkg::STATUS_CLOSED;
               end else begin
                  scan_ctrl.start       = 1'b1;
                  scan_ctrl.select_mode = 1'b1;
                  rsp_valid_in          = 1'b0;
                  state_in              = ST_SCAN;
               end
            end else if (req_opcode_ff == jst_pkg::OP_CLOSE) begin
               if (close_in_range && scan_stat.close_occ) begin
                  // Closing a slot that was never claimed takes it out of
                  // the new count as well, so both counts stay exact.
                  if (!scan_stat.close_own && new_count_ff != '0) begin
                     new_count_in = new_count_ff - 1'b1;
                  end
                  if (empty_count_ff < FULL_COUNT) begin
                     empty_count_in = empty_count_ff + 1'b1;
                  end
                  scan_ctrl.close = 1'b1;
                  rsp_status_in   = jst_pkg::STATUS_OK;
                  rsp_slot_in     = req_close_ff;
               end
            end
         end

         ST_SCAN: begin
            if (scan_stat.hit) begin
               rsp_status_in = jst_pkg::STATUS_OK;
               rsp_slot_in   = 4'(scan_slot);
               if (req_opcode_ff == jst_pkg::OP_SELECT) begin
                  // The claimed job's details come from memory next cycle.
                  ram_rd_en    = 1'b1;
                  new_count_in = new_count_ff - 1'b1;
                  state_in     = ST_FETCH;
               end else begin
                  ram_wr_en      = 1'b1;
                  rsp_job_id_in  = next_id_ff;
                  next_id_in     = next_id_ff + 1'b1;
                  empty_count_in = empty_count_ff - 1'b1;
                  new_count_in   = new_count_ff + 1'b1;
                  rsp_valid_in   = 1'b1;
                  state_in       = ST_IDLE;
               end
            end else if (scan_stat.miss) begin
               rsp_status_in = jst_pkg::STATUS_INVALID;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end

         ST_FETCH: begin
            rsp_job_id_in = id_rd;
            rsp_class_in  = class_rd;
            rsp_name_in   = name_rd;
            rsp_valid_in  = 1'b1;
            state_in      = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_all_empty_in = rsp_valid_in ? (empty_count_in == FULL_COUNT)
                                      : rsp_all_empty_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         accepting_ff   <= 1'b1;
         new_count_ff   <= '0;
         empty_count_ff <= FULL_COUNT;
         next_id_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         accepting_ff   <= accepting_in;
         new_count_ff   <= new_count_in;
         empty_count_ff <= empty_count_in;
         next_id_ff     <= next_id_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      req_opcode_ff    <= req_opcode_in;
      req_class_ff     <= req_class_in;
      req_name_ff      <= req_name_in;
      req_owner_ff     <= req_owner_in;
      req_close_ff     <= req_close_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_slot_ff      <= rsp_slot_in;
      rsp_job_id_ff    <= rsp_job_id_in;
      rsp_class_ff     <= rsp_class_in;
      rsp_name_ff      <= rsp_name_in;
      rsp_all_empty_ff <= rsp_all_empty_in;
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_slot      = rsp_slot_ff;
   assign rsp_job_id    = rsp_job_id_ff;
   assign rsp_class_out = rsp_class_ff;
   assign rsp_name_out  = rsp_name_ff;
   assign rsp_all_empty = rsp_all_empty_ff;

endmodule
